FILE: src/sdes_pkg.sv
// shared types, constants and the divider step for the stick dead-zone scaler
// no dependencies; every other file uses it through scoped names
`default_nettype none

package sdes_pkg;

	localparam int AXIS_W     = 16;
	localparam int LEVEL_W    = 15;
	localparam int QUO_W      = 15;
	localparam int DIV_BITS   = 3;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;
	// front end two stages, divider stages, output register
	localparam int NUM_STG    = DIV_STAGES + 3;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd32767;

	// configuration register indexes
	localparam logic REG_DEAD_ZONE = 1'b0;
	localparam logic REG_EDGE      = 1'b1;

	typedef struct packed {
		logic [AXIS_W-1:0] rem;
		logic [QUO_W-1:0]  lo;
		logic [QUO_W-1:0]  quo;
	} axis_t;

	typedef struct packed {
		logic                     pass;
		logic signed [AXIS_W-1:0] raw_x;
		logic signed [AXIS_W-1:0] raw_y;
		logic [AXIS_W-1:0]        d;
		axis_t                    ax;
		axis_t                    ay;
	} div_t;

	// restoring division, DIV_BITS quotient bits per call
	function automatic axis_t div_step(axis_t a, logic [AXIS_W-1:0] d);
		axis_t           r;
		logic [AXIS_W:0] part;
		r = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			part = {r.rem, r.lo[QUO_W-1]};
			r.lo = {r.lo[QUO_W-2:0], 1'b0};
			if (part >= {1'b0, d}) begin
				part = part - {1'b0, d};
				r.quo = {r.quo[QUO_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[QUO_W-2:0], 1'b0};
			end
			r.rem = part[AXIS_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/sdes_if.sv
// valid/ready channel interfaces for stick samples and scaled results
// payload widths come from sdes_pkg
`default_nettype none

interface sdes_stick_if;
	logic                              valid;
	logic                              ready;
	logic signed [sdes_pkg::AXIS_W-1:0] stick_x;
	logic signed [sdes_pkg::AXIS_W-1:0] stick_y;
	modport source(output valid, output stick_x, output stick_y, input ready);
	modport sink(input valid, input stick_x, input stick_y, output ready);
endinterface

interface sdes_scaled_if;
	logic                              valid;
	logic                              ready;
	logic signed [sdes_pkg::AXIS_W-1:0] scaled_x;
	logic signed [sdes_pkg::AXIS_W-1:0] scaled_y;
	modport source(output valid, output scaled_x, output scaled_y, input ready);
	modport sink(input valid, input scaled_x, input scaled_y, output ready);
endinterface

`default_nettype wire

FILE: src/stick_deadzone_edge_scaler.sv
// top level of the stick dead-zone and edge scaler
// depends on sdes_pkg, sdes_if, sdes_front and sdes_div_stage
//
// Usage:
//   stick  : valid/ready sink, one X/Y sample per word.
//   scaled : valid/ready source, one scaled X/Y word per sample, in order.
//   cfg    : write enable, register index (0 dead zone, 1 edge level) and
//            15-bit data; write only while no word is in flight.
//   The result word passes through eight registers in a row: two front
//   stages, five divider stages of three quotient bits each and the
//   output register.
//   Throughput is one word per cycle while the receiver takes words; the 15-bit
//   quotient split over the divider stages sets the depth.
//   Each stage advances whenever it is empty or the stage after it
//   advances, so bubbles close up and stick.ready stays high while any
//   stage is free, even when the receiver holds the output word.
//   When the receiver stalls with every stage full, stick.ready drops.
//   Reset clears all valid bits and sets dead zone 0 and edge level 32767.
`default_nettype none

module stick_deadzone_edge_scaler (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_idx,
	input  wire logic [sdes_pkg::LEVEL_W-1:0] cfg_wdata,
	sdes_stick_if.sink                        stick,
	sdes_scaled_if.source                     scaled
);

	localparam int NS = sdes_pkg::NUM_STG;
	localparam int ND = sdes_pkg::DIV_STAGES;

	logic [sdes_pkg::LEVEL_W-1:0]       dead_zone_q, edge_q;
	logic [NS-1:0]                      vld_q;
	logic [NS-1:0]                      en;
	sdes_pkg::div_t                     div_pipe [ND+1];
	sdes_pkg::div_t                     last;
	logic signed [sdes_pkg::AXIS_W-1:0] out_x, out_y;
	logic signed [sdes_pkg::AXIS_W-1:0] scaled_x_s8, scaled_y_s8;
	logic                               pass_s8, zero_x_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= '0;
			edge_q      <= sdes_pkg::FULL_SCALE;
		end else if (cfg_we) begin
			case (cfg_idx)
				sdes_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg_wdata;
				sdes_pkg::REG_EDGE:      edge_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or its successor moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || scaled.ready;
		for (int i = NS-2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= stick.valid;
			for (int i = 1; i < NS; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign stick.ready = en[0];

	sdes_front u_front (
		.clk       (clk),
		.en_s1     (en[0]),
		.en_s2     (en[1]),
		.stick_x   (stick.stick_x),
		.stick_y   (stick.stick_y),
		.dead_zone (dead_zone_q),
		.edge_lvl  (edge_q),
		.front_s2  (div_pipe[0])
	);

	for (genvar k = 0; k < ND; k++) begin : g_div
		sdes_div_stage u_div (
			.clk    (clk),
			.en     (en[k+2]),
			.div_in (div_pipe[k]),
			.div_sk (div_pipe[k+1])
		);
	end

	assign last = div_pipe[ND];

	// apply sign after the division, raw sample on passthrough
	always_comb begin
		if (last.pass) begin
			out_x = last.raw_x;
			out_y = last.raw_y;
		end else begin
			out_x = last.raw_x[sdes_pkg::AXIS_W-1] ? -$signed({1'b0, last.ax.quo})
			                                       : $signed({1'b0, last.ax.quo});
			out_y = last.raw_y[sdes_pkg::AXIS_W-1] ? -$signed({1'b0, last.ay.quo})
			                                       : $signed({1'b0, last.ay.quo});
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			scaled_x_s8 <= out_x;
			scaled_y_s8 <= out_y;
			pass_s8     <= last.pass;
			zero_x_s8   <= (last.raw_x == '0);
		end
	end

	assign scaled.valid    = vld_q[NS-1];
	assign scaled.scaled_x = scaled_x_s8;
	assign scaled.scaled_y = scaled_y_s8;

	// ready low only when every stage holds a word
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!stick.ready |-> &vld_q)
		else $error("input stalled with a free stage");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS-2] && !last.pass) |-> (last.ax.rem < last.d && last.ay.rem < last.d))
		else $error("divider remainder out of range");

	// scaled result never reaches the most negative code
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		(scaled.valid && !pass_s8) |->
		(scaled.scaled_x != 16'sh8000 && scaled.scaled_y != 16'sh8000))
		else $error("scaled magnitude above full scale");

	// a zero X axis gives zero
	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(scaled.valid && !pass_s8 && zero_x_s8) |-> (scaled.scaled_x == '0))
		else $error("zero X axis gave nonzero result");

endmodule

`default_nettype wire

FILE: src/sdes_front.sv
// first two pipeline stages: axis magnitudes, dead-zone excess, divisor and
// scaled numerators; uses sdes_pkg
`default_nettype none

module sdes_front (
	input  wire logic                              clk,
	input  wire logic                              en_s1,
	input  wire logic                              en_s2,
	input  wire logic signed [sdes_pkg::AXIS_W-1:0] stick_x,
	input  wire logic signed [sdes_pkg::AXIS_W-1:0] stick_y,
	input  wire logic [sdes_pkg::LEVEL_W-1:0]       dead_zone,
	input  wire logic [sdes_pkg::LEVEL_W-1:0]       edge_lvl,
	output sdes_pkg::div_t                          front_s2
);

	logic [sdes_pkg::AXIS_W-1:0]        mag_x, mag_y, dz_ext;
	logic [sdes_pkg::AXIS_W-1:0]        nx, ny;
	logic [sdes_pkg::LEVEL_W-1:0]       span;
	logic                               pass;

	logic                               pass_s1;
	logic signed [sdes_pkg::AXIS_W-1:0] raw_x_s1, raw_y_s1;
	logic [sdes_pkg::AXIS_W-1:0]        nx_s1, ny_s1;
	logic [sdes_pkg::LEVEL_W-1:0]       span_s1;

	logic [sdes_pkg::AXIS_W-1:0]        dmax;
	logic [2*sdes_pkg::QUO_W:0]         num_x, num_y;
	sdes_pkg::div_t                     nxt;

	// stage 1: magnitudes (most negative sample gives 32768) and excess
	always_comb begin
		dz_ext = {1'b0, dead_zone};
		mag_x  = stick_x[sdes_pkg::AXIS_W-1] ? (~stick_x + 16'd1) : stick_x;
		mag_y  = stick_y[sdes_pkg::AXIS_W-1] ? (~stick_y + 16'd1) : stick_y;
		nx     = (mag_x > dz_ext) ? (mag_x - dz_ext) : '0;
		ny     = (mag_y > dz_ext) ? (mag_y - dz_ext) : '0;
		pass   = !(edge_lvl > dead_zone);
		span   = edge_lvl - dead_zone;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pass_s1  <= pass;
			raw_x_s1 <= stick_x;
			raw_y_s1 <= stick_y;
			nx_s1    <= nx;
			ny_s1    <= ny;
			span_s1  <= span;
		end
	end

	// stage 2: divisor is the largest of span and both excesses,
	// numerators are 32767 * excess, below 2^30
	always_comb begin
		dmax = {1'b0, span_s1};
		if (nx_s1 > dmax)
			dmax = nx_s1;
		if (ny_s1 > dmax)
			dmax = ny_s1;
		num_x = {nx_s1, 15'd0} - {15'd0, nx_s1};
		num_y = {ny_s1, 15'd0} - {15'd0, ny_s1};

		nxt.pass   = pass_s1;
		nxt.raw_x  = raw_x_s1;
		nxt.raw_y  = raw_y_s1;
		nxt.d      = dmax;
		nxt.ax.rem = {1'b0, num_x[2*sdes_pkg::QUO_W-1:sdes_pkg::QUO_W]};
		nxt.ax.lo  = num_x[sdes_pkg::QUO_W-1:0];
		nxt.ax.quo = '0;
		nxt.ay.rem = {1'b0, num_y[2*sdes_pkg::QUO_W-1:sdes_pkg::QUO_W]};
		nxt.ay.lo  = num_y[sdes_pkg::QUO_W-1:0];
		nxt.ay.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (en_s2)
			front_s2 <= nxt;
	end

endmodule

`default_nettype wire

FILE: src/sdes_div_stage.sv
// one divider stage: three quotient bits for both axes against the shared divisor
// uses sdes_pkg::div_step
`default_nettype none

module sdes_div_stage (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire sdes_pkg::div_t div_in,
	output sdes_pkg::div_t     div_sk
);

	sdes_pkg::div_t nxt;

	always_comb begin
		nxt    = div_in;
		nxt.ax = sdes_pkg::div_step(div_in.ax, div_in.d);
		nxt.ay = sdes_pkg::div_step(div_in.ay, div_in.d);
	end

	always_ff @(posedge clk) begin
		if (en)
			div_sk <= nxt;
	end

endmodule

`default_nettype wire
